[hw/rtl/utf8sd_pkg.sv]
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types, constants and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int MAX_UNITS   = 4;

	localparam logic        ACT_EOT    = 1'b1;
	localparam logic [20:0] BAD_BASE   = 21'h110000;
	localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_LEN2   = 21'h000080;
	localparam logic [20:0] MIN_LEN3   = 21'h000800;
	localparam logic [20:0] MIN_LEN4   = 21'h010000;

	typedef logic [OFFSET_BITS-1:0] pos_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_valid;
		logic [2:0]  unit_length;
		logic [31:0] start_offset;
	} unit_t;

	typedef struct packed {
		unit_t [MAX_UNITS-1:0] units;
		logic  [2:0]           count;
	} group_t;

	typedef struct packed {
		logic [2:0] seq_len;
		logic [1:0] seen;
		logic       pos_zero;
	} dec_status_t;

	function automatic logic [31:0] off32(pos_t p);
		logic [63:0] w;
		w = 64'(p);
		return w[31:0];
	endfunction

	function automatic unit_t bad_unit(logic [7:0] b, pos_t p);
		unit_t u;
		u.code_point   = BAD_BASE + {13'd0, b};
		u.is_valid     = 1'b0;
		u.unit_length  = 3'd1;
		u.start_offset = off32(p);
		return u;
	endfunction

endpackage

[hw/rtl/utf8sd_in_if.sv]
// ----------------------------------------------------------------------------
// utf8sd_in_if
// Byte request channel: action and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface utf8sd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

[hw/rtl/utf8sd_out_if.sv]
// ----------------------------------------------------------------------------
// utf8sd_out_if
// Decoded unit channel with valid/ready.
// ----------------------------------------------------------------------------
interface utf8sd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        is_valid;
	logic [2:0]  unit_length;
	logic [31:0] start_offset;
	logic        last_of_run;

	modport source (output valid, output code_point, output is_valid, output unit_length,
		output start_offset, output last_of_run, input ready);
	modport sink (input valid, input code_point, input is_valid, input unit_length,
		input start_offset, input last_of_run, output ready);
endinterface

[hw/rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder with validation and replay of rejected bytes.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   bytes   | in  | action, data_byte
//   units   | out | code_point, is_valid, unit_length, start_offset, last_of_run
//
// One request per cycle while bytes.ready is high; a request that yields units
// holds bytes.ready low until its last unit leaves the unit buffer, which drains
// one unit per cycle unless stalled; each unit passes the buffer, then output reg.
// units.ready low stalls the output register; an empty buffer still takes a request.
// arst_n clears sequence state, offset and all valid flags.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic         clk,
	input  logic         arst_n,
	utf8sd_in_if.sink    bytes,
	utf8sd_out_if.source units
);

	logic                    accept;
	logic                    in_ready;
	logic [2:0]              rem;
	utf8sd_pkg::group_t      grp;
	utf8sd_pkg::dec_status_t status;

	assign bytes.ready = in_ready;
	assign accept      = bytes.valid && in_ready;

	utf8sd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (bytes.action),
		.data_byte (bytes.data_byte),
		.grp       (grp),
		.status    (status)
	);

	utf8sd_drain u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.grp      (grp),
		.in_ready (in_ready),
		.rem      (rem),
		.units    (units)
	);

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(status.seq_len == 3'd0) ? (status.seen == 2'd0)
			: ((status.seq_len >= 3'd2) && (status.seq_len <= 3'd4) &&
			   ({1'b0, status.seen} + 3'd2 <= status.seq_len)))
		else $error("pending sequence count out of range");

	a_eot_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (bytes.action == utf8sd_pkg::ACT_EOT)) |=>
			(status.pos_zero && (status.seq_len == 3'd0)))
		else $error("end of text did not clear offset and sequence");

	a_bad_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && !units.is_valid) |->
			((units.unit_length == 3'd1) && (units.code_point >= utf8sd_pkg::BAD_BASE)))
		else $error("rejected unit malformed");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rem <= 3'(utf8sd_pkg::MAX_UNITS)) &&
			(!accept || (grp.count <= 3'(utf8sd_pkg::MAX_UNITS))))
		else $error("unit buffer overflow");

endmodule

[hw/rtl/utf8sd_decode.sv]
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and single-pass decode of one request into up to four units.
// ----------------------------------------------------------------------------
module utf8sd_decode (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    action,
	input  logic [7:0]              data_byte,
	output utf8sd_pkg::group_t      grp,
	output utf8sd_pkg::dec_status_t status
);

	logic [7:0]       lead_q, lead_d;
	logic [2:0]       seq_q, seq_d;
	logic [1:0]       seen_q, seen_d;
	logic [20:0]      acc_q, acc_d;
	logic [7:0]       cb_q [2];
	utf8sd_pkg::pos_t pos_q, pos_d;
	logic             cb_we;

	utf8sd_pkg::pos_t lo;
	logic [20:0]      acc_new;
	logic [20:0]      minimum;
	logic             ok;
	logic             do_rej;
	logic             do_fresh;
	logic             tail_valid;
	utf8sd_pkg::unit_t tail;
	logic [2:0]       n;

	always_comb begin
		lead_d     = lead_q;
		seq_d      = seq_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		pos_d      = pos_q;
		cb_we      = 1'b0;
		do_rej     = 1'b0;
		do_fresh   = 1'b0;
		tail_valid = 1'b0;
		tail       = '0;
		grp        = '0;
		n          = 3'd0;

		lo      = pos_q - utf8sd_pkg::pos_t'(1) - utf8sd_pkg::pos_t'(seen_q);
		acc_new = {acc_q[14:0], data_byte[5:0]};
		unique case (seq_q)
			3'd2:    minimum = utf8sd_pkg::MIN_LEN2;
			3'd3:    minimum = utf8sd_pkg::MIN_LEN3;
			default: minimum = utf8sd_pkg::MIN_LEN4;
		endcase
		ok = (acc_new >= minimum) && (acc_new <= utf8sd_pkg::MAX_SCALAR) &&
			!((acc_new >= utf8sd_pkg::SURR_LO) && (acc_new <= utf8sd_pkg::SURR_HI));

		if (action == utf8sd_pkg::ACT_EOT) begin
			do_rej = (seq_q != 3'd0);
			seq_d  = 3'd0;
			seen_d = 2'd0;
			acc_d  = '0;
			pos_d  = '0;
		end else begin
			pos_d = pos_q + utf8sd_pkg::pos_t'(1);
			if (seq_q == 3'd0) begin
				do_fresh = 1'b1;
			end else if (data_byte[7:6] == 2'b10) begin
				if (({1'b0, seen_q} + 3'd2) >= seq_q) begin
					seq_d      = 3'd0;
					seen_d     = 2'd0;
					acc_d      = '0;
					tail_valid = 1'b1;
					if (ok) begin
						tail.code_point   = acc_new;
						tail.is_valid     = 1'b1;
						tail.unit_length  = seq_q;
						tail.start_offset = utf8sd_pkg::off32(lo);
					end else begin
						do_rej = 1'b1;
						tail   = utf8sd_pkg::bad_unit(data_byte, pos_q);
					end
				end else begin
					acc_d  = acc_new;
					cb_we  = 1'b1;
					seen_d = seen_q + 2'd1;
				end
			end else begin
				do_rej   = 1'b1;
				do_fresh = 1'b1;
			end
		end

		if (do_fresh) begin
			seq_d  = 3'd0;
			seen_d = 2'd0;
			acc_d  = '0;
			priority if (!data_byte[7]) begin
				tail_valid        = 1'b1;
				tail.code_point   = {13'd0, data_byte};
				tail.is_valid     = 1'b1;
				tail.unit_length  = 3'd1;
				tail.start_offset = utf8sd_pkg::off32(pos_q);
			end else if (data_byte[7:5] == 3'b110) begin
				lead_d = data_byte;
				seq_d  = 3'd2;
				acc_d  = {16'd0, data_byte[4:0]};
			end else if (data_byte[7:4] == 4'b1110) begin
				lead_d = data_byte;
				seq_d  = 3'd3;
				acc_d  = {17'd0, data_byte[3:0]};
			end else if (data_byte[7:3] == 5'b11110) begin
				lead_d = data_byte;
				seq_d  = 3'd4;
				acc_d  = {18'd0, data_byte[2:0]};
			end else begin
				tail_valid = 1'b1;
				tail       = utf8sd_pkg::bad_unit(data_byte, pos_q);
			end
		end

		if (do_rej) begin
			grp.units[n[1:0]] = utf8sd_pkg::bad_unit(lead_q, lo);
			n = n + 3'd1;
			if (seen_q >= 2'd1) begin
				grp.units[n[1:0]] = utf8sd_pkg::bad_unit(cb_q[0], lo + utf8sd_pkg::pos_t'(1));
				n = n + 3'd1;
			end
			if (seen_q >= 2'd2) begin
				grp.units[n[1:0]] = utf8sd_pkg::bad_unit(cb_q[1], lo + utf8sd_pkg::pos_t'(2));
				n = n + 3'd1;
			end
		end
		if (tail_valid) begin
			grp.units[n[1:0]] = tail;
			n = n + 3'd1;
		end
		grp.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			seq_q  <= '0;
			seen_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			lead_q <= lead_d;
			seq_q  <= seq_d;
			seen_q <= seen_d;
			acc_q  <= acc_d;
			pos_q  <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cb_we) begin
			cb_q[seen_q[0]] <= data_byte;
		end
	end

	assign status.seq_len  = seq_q;
	assign status.seen     = seen_q;
	assign status.pos_zero = (pos_q == '0);

endmodule

[hw/rtl/utf8sd_drain.sv]
// ----------------------------------------------------------------------------
// utf8sd_drain
// Unit group buffer and output register; one unit per cycle unless stalled.
// ----------------------------------------------------------------------------
module utf8sd_drain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  utf8sd_pkg::group_t   grp,
	output logic                 in_ready,
	output logic [2:0]           rem,
	utf8sd_out_if.source         units
);

	utf8sd_pkg::unit_t [utf8sd_pkg::MAX_UNITS-1:0] buf_q;
	logic [2:0]        rem_q;
	utf8sd_pkg::unit_t out_q;
	logic              out_last_q;
	logic              out_vld_q;
	logic              pop;

	assign pop      = (rem_q != 3'd0) && (!out_vld_q || units.ready);
	assign in_ready = (rem_q == 3'd0) || ((rem_q == 3'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= grp.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= grp.units;
		end else if (pop) begin
			buf_q <= {buf_q[utf8sd_pkg::MAX_UNITS-1], buf_q[utf8sd_pkg::MAX_UNITS-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop) begin
			out_vld_q <= 1'b1;
		end else if (units.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q      <= buf_q[0];
			out_last_q <= (rem_q == 3'd1);
		end
	end

	assign rem                = rem_q;
	assign units.valid        = out_vld_q;
	assign units.code_point   = out_q.code_point;
	assign units.is_valid     = out_q.is_valid;
	assign units.unit_length  = out_q.unit_length;
	assign units.start_offset = out_q.start_offset;
	assign units.last_of_run  = out_last_q;

endmodule
